// ===== sv/lpcd_pkg.sv =====
// Package for the LRU pair cache directory: sizes, operation codes and the
// request, response and cell control types. No dependencies.
`timescale 1ns / 1ps

package lpcd_pkg;

  // directory depth and derived widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // fixed field widths of the request and response
  localparam int PHONE_W   = 8;
  localparam int KEY_W     = 2 * PHONE_W;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  // width wide enough to compare count and capacity against each other
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_PRELOAD = 2'd1,
    OP_CLEAR   = 2'd2
  } lpcd_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PHONE_W-1:0] first_phone;
    logic [PHONE_W-1:0] second_phone;
  } lpcd_req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               fill_needed;
    logic               accepted;
    logic [COUNT_W-1:0] entry_count;
  } lpcd_rsp_t;

  // update command for one directory cell
  typedef struct packed {
    logic shift;  // take key and slot from the neighbor in front
    logic load;   // take the broadcast key and slot
  } lpcd_cell_ctrl_t;

endpackage

// ===== sv/lpcd_cell.sv =====
// One directory position: holds a key and its buffer slot, compares against
// the lookup key and passes match, hit slot and tail slot down the row.
// Depends on lpcd_pkg.
`timescale 1ns / 1ps

module lpcd_cell (
  input  logic                        clk_i,
  input  lpcd_pkg::lpcd_cell_ctrl_t   ctrl_i,
  input  logic                        valid_i,
  input  logic                        tail_i,
  input  logic [lpcd_pkg::KEY_W-1:0]  key_i,
  input  logic [lpcd_pkg::IDX_W-1:0]  new_slot_i,
  input  logic [lpcd_pkg::KEY_W-1:0]  prev_key_i,
  input  logic [lpcd_pkg::IDX_W-1:0]  prev_slot_i,
  input  logic                        found_i,
  input  logic [lpcd_pkg::IDX_W-1:0]  hit_slot_i,
  input  logic [lpcd_pkg::IDX_W-1:0]  tail_slot_i,
  output logic                        found_o,
  output logic [lpcd_pkg::IDX_W-1:0]  hit_slot_o,
  output logic [lpcd_pkg::IDX_W-1:0]  tail_slot_o,
  output logic [lpcd_pkg::KEY_W-1:0]  key_o,
  output logic [lpcd_pkg::IDX_W-1:0]  slot_o
);

  logic [lpcd_pkg::KEY_W-1:0] key_q;
  logic [lpcd_pkg::IDX_W-1:0] slot_q;
  logic                       match;

  // compare against the lookup key, first match in the row wins
  assign match       = valid_i && (key_q == key_i);
  assign found_o     = found_i || match;
  assign hit_slot_o  = found_i ? hit_slot_i : (match ? slot_q : '0);
  assign tail_slot_o = tail_i ? slot_q : tail_slot_i;

  // hand stored entry to the next cell
  assign key_o  = key_q;
  assign slot_o = slot_q;

  // shift from the neighbor or load the broadcast entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q  <= prev_key_i;
      slot_q <= prev_slot_i;
    end else if (ctrl_i.load) begin
      key_q  <= key_i;
      slot_q <= new_slot_i;
    end
  end

endmodule

// ===== sv/lru_pair_cache_directory.sv =====
// Top level of the LRU pair cache directory: command port, capacity register,
// entry count and the row of lpcd_cell instances. Depends on lpcd_pkg, lpcd_cell.
`timescale 1ns / 1ps

// Recency-ordered directory of a fully associative cache. A command is taken
// on any cycle with start_i high; busy_o never rises, so one command per clock
// is sustained. Every command gives exactly one response, shown on rsp_o for
// the single cycle in which done_o is high, the cycle right after the command
// is taken; the receiver cannot stall it. The rate is set by the cell row:
// all cells compare the key in parallel, the first match and the tail slot
// ripple down the row, and every cell shifts or loads at the same edge.
// The capacity register may be written at any time through cfg_valid_i.
module lru_pair_cache_directory (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  lpcd_pkg::lpcd_req_t        req_i,
  output logic                       done_o,
  output lpcd_pkg::lpcd_rsp_t        rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lpcd_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int N = lpcd_pkg::ENTRIES;

  logic [lpcd_pkg::CAP_W-1:0] cap_q;
  logic [lpcd_pkg::CNT_W-1:0] count_q, count_d;
  logic                       done_q;
  lpcd_pkg::lpcd_rsp_t        rsp_q, rsp_d;

  logic                       take;
  logic [lpcd_pkg::KEY_W-1:0] key;
  logic [lpcd_pkg::CMP_W-1:0] eff_cap;
  logic [lpcd_pkg::CMP_W-1:0] count_ext;
  logic                       below_cap;
  logic                       is_lookup, is_preload, is_clear;
  logic                       hit;
  logic [lpcd_pkg::IDX_W-1:0] new_slot;

  // ripple chains through the row
  logic [lpcd_pkg::KEY_W-1:0] key_chain  [N+1];
  logic [lpcd_pkg::IDX_W-1:0] slot_chain [N+1];
  logic                       found_chain[N+1];
  logic [lpcd_pkg::IDX_W-1:0] hit_chain  [N+1];
  logic [lpcd_pkg::IDX_W-1:0] tail_chain [N+1];

  assign take        = start_i;
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign key         = {req_i.first_phone, req_i.second_phone};

  assign is_lookup  = (req_i.operation == lpcd_pkg::OP_LOOKUP);
  assign is_preload = (req_i.operation == lpcd_pkg::OP_PRELOAD);
  assign is_clear   = (req_i.operation == lpcd_pkg::OP_CLEAR);

  // capacity clamped to one .. entries
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lpcd_pkg::CMP_W'(1);
    end else if (lpcd_pkg::CMP_W'(cap_q) > lpcd_pkg::CMP_W'(N)) begin
      eff_cap = lpcd_pkg::CMP_W'(N);
    end else begin
      eff_cap = lpcd_pkg::CMP_W'(cap_q);
    end
  end

  assign count_ext = lpcd_pkg::CMP_W'(count_q);
  assign below_cap = count_ext < eff_cap;

  // chain heads: cell zero receives the new front entry
  assign key_chain[0]   = key;
  assign slot_chain[0]  = new_slot;
  assign found_chain[0] = 1'b0;
  assign hit_chain[0]   = '0;
  assign tail_chain[0]  = '0;

  assign hit = found_chain[N];

  // slot given to the front entry or the appended entry
  always_comb begin
    if (is_lookup && hit) begin
      new_slot = hit_chain[N];
    end else if (is_lookup && !below_cap) begin
      new_slot = tail_chain[N];
    end else begin
      new_slot = lpcd_pkg::IDX_W'(count_q);
    end
  end

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    lpcd_pkg::lpcd_cell_ctrl_t ctrl;
    logic                      valid;
    logic                      tail;

    assign valid = lpcd_pkg::CNT_W'(i) < count_q;
    assign tail  = lpcd_pkg::CNT_W'(i + 1) == count_q;

    // hit: cells up to the match shift; miss: cells up to the insert point shift; preload: cell at the count loads
    always_comb begin
      ctrl.shift = 1'b0;
      ctrl.load  = 1'b0;
      if (take && is_lookup) begin
        if (hit) begin
          ctrl.shift = !found_chain[i];
        end else if (below_cap) begin
          ctrl.shift = lpcd_pkg::CNT_W'(i) <= count_q;
        end else begin
          ctrl.shift = valid;
        end
      end else if (take && is_preload && below_cap) begin
        ctrl.load = lpcd_pkg::CNT_W'(i) == count_q;
      end
    end

    lpcd_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid),
      .tail_i      (tail),
      .key_i       (key),
      .new_slot_i  (new_slot),
      .prev_key_i  (key_chain[i]),
      .prev_slot_i (slot_chain[i]),
      .found_i     (found_chain[i]),
      .hit_slot_i  (hit_chain[i]),
      .tail_slot_i (tail_chain[i]),
      .found_o     (found_chain[i+1]),
      .hit_slot_o  (hit_chain[i+1]),
      .tail_slot_o (tail_chain[i+1]),
      .key_o       (key_chain[i+1]),
      .slot_o      (slot_chain[i+1])
    );
  end

  // next count and response
  always_comb begin
    count_d           = count_q;
    rsp_d.hit         = 1'b0;
    rsp_d.slot        = '0;
    rsp_d.fill_needed = 1'b0;
    rsp_d.accepted    = 1'b1;
    if (is_lookup) begin
      rsp_d.hit         = hit;
      rsp_d.fill_needed = !hit;
      rsp_d.slot        = lpcd_pkg::SLOT_W'(new_slot);
      if (!hit && below_cap) begin
        count_d = count_q + 1'b1;
      end
    end else if (is_preload) begin
      if (below_cap) begin
        rsp_d.fill_needed = 1'b1;
        rsp_d.slot        = lpcd_pkg::SLOT_W'(new_slot);
        count_d           = count_q + 1'b1;
      end else begin
        rsp_d.accepted = 1'b0;
      end
    end else if (is_clear) begin
      count_d = '0;
    end
    rsp_d.entry_count = lpcd_pkg::COUNT_W'(count_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= lpcd_pkg::CAP_W'(lpcd_pkg::CAP_RESET);
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (take) begin
        count_q <= count_d;
      end
      done_q <= take;
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/lpcd_checker.sv =====
// Port-level checks for the LRU pair cache directory, bound to the top level.
// Depends on lpcd_pkg and lru_pair_cache_directory.
`timescale 1ns / 1ps

module lpcd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input lpcd_pkg::lpcd_req_t        req_i,
  input logic                       done_o,
  input lpcd_pkg::lpcd_rsp_t        rsp_o
);

  // one response for each transfer, in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("response missing after command transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("response without command transfer");

  // a refused command can only be a preload
  a_refuse_preload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.accepted) |->
      ($past(req_i.operation) == lpcd_pkg::OP_PRELOAD))
    else $error("non-preload command refused");

  // a hit is a lookup and never asks for a fill
  a_hit_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.hit) |->
      (!rsp_o.fill_needed && ($past(req_i.operation) == lpcd_pkg::OP_LOOKUP)))
    else $error("hit on wrong operation or with fill request");

  // clear empties the directory
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.operation == lpcd_pkg::OP_CLEAR) |=>
      (rsp_o.entry_count == '0))
    else $error("clear left entries");

endmodule

bind lru_pair_cache_directory lpcd_checker u_lpcd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

// ===== tb/tb_lru_pair_cache_directory.sv =====
// Self-checking testbench for lru_pair_cache_directory: directed and random
// commands, capacity changes between phases, and a recency-order predictor.
// Depends on lpcd_pkg and the lru_pair_cache_directory RTL.
`timescale 1ns / 1ps

module tb_lru_pair_cache_directory;

  // code with no operation behind it, outside the package enum
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 50;

  typedef struct {
    lpcd_pkg::lpcd_rsp_t rsp;
    int                  item;
  } dir_expect_t;

  logic                lpcd_clk_unused_dummy;
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  lpcd_pkg::lpcd_req_t req_i       = '0;
  logic                cfg_valid_i = 1'b0;
  logic [lpcd_pkg::CAP_W-1:0] cfg_data_i = '0;
  logic                busy_o;
  logic                done_o;
  lpcd_pkg::lpcd_rsp_t rsp_o;
  logic                cfg_ready_o;

  lru_pair_cache_directory u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state: recency-ordered keys and slots, count and capacity
  logic [lpcd_pkg::KEY_W-1:0]  dir_key [lpcd_pkg::ENTRIES];
  logic [lpcd_pkg::SLOT_W-1:0] dir_slot[lpcd_pkg::ENTRIES];
  int                          dir_count = 0;
  logic [lpcd_pkg::CAP_W-1:0]  dir_cap = lpcd_pkg::CAP_W'(lpcd_pkg::CAP_RESET);

  lpcd_pkg::lpcd_req_t        pending_q[$];
  dir_expect_t                expect_q[$];
  logic [lpcd_pkg::KEY_W-1:0] key_pool[$];

  int  send_gap_pct = 0;
  bit  send_hold    = 1'b0;
  logic req_taken   = 1'b0;
  int  items_taken  = 0;
  int  err_count    = 0;
  int  idle_cycles  = 0;
  int  hit_count    = 0;
  int  fill_count   = 0;
  int  refused_count = 0;
  int  clear_count  = 0;
  int  cfg_count    = 0;
  dir_expect_t front;

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input int item, input string what, input int got,
                                 input int want);
    if (err_count < MAX_REPORTS) begin
      $display("mismatch at item %0d: %s got %0d expected %0d", item, what, got, want);
    end
    err_count++;
  endtask

  // effective capacity, then one command applied to the directory
  function automatic lpcd_pkg::lpcd_rsp_t predict_directory(input lpcd_pkg::lpcd_req_t r);
    lpcd_pkg::lpcd_rsp_t         rsp;
    logic [lpcd_pkg::KEY_W-1:0]  key;
    logic [lpcd_pkg::SLOT_W-1:0] s;
    int cap;
    int pos;
    int i;
    rsp = '0;
    rsp.accepted = 1'b1;
    key = {r.first_phone, r.second_phone};
    s = '0;
    cap = (dir_cap == 0) ? 1 :
          ((int'(dir_cap) > lpcd_pkg::ENTRIES) ? lpcd_pkg::ENTRIES : int'(dir_cap));
    case (r.operation)
      lpcd_pkg::OP_LOOKUP: begin
        pos = -1;
        for (i = 0; i < dir_count; i++) begin
          if (pos < 0 && dir_key[i] == key) pos = i;
        end
        if (pos >= 0) begin
          rsp.hit = 1'b1;
          s = dir_slot[pos];
        end else begin
          rsp.fill_needed = 1'b1;
          if (dir_count < cap) begin
            s = lpcd_pkg::SLOT_W'(dir_count);
            dir_count++;
            pos = dir_count - 1;
          end else begin
            pos = dir_count - 1;
            s = dir_slot[pos];
          end
        end
        // move to front, everything ahead of it shifts back by one
        for (i = pos; i > 0; i--) begin
          dir_key[i]  = dir_key[i-1];
          dir_slot[i] = dir_slot[i-1];
        end
        dir_key[0]  = key;
        dir_slot[0] = s;
        rsp.slot = s;
      end
      lpcd_pkg::OP_PRELOAD: begin
        if (dir_count < cap) begin
          rsp.slot = lpcd_pkg::SLOT_W'(dir_count);
          dir_key[dir_count]  = key;
          dir_slot[dir_count] = lpcd_pkg::SLOT_W'(dir_count);
          dir_count++;
          rsp.fill_needed = 1'b1;
        end else begin
          rsp.accepted = 1'b0;
        end
      end
      lpcd_pkg::OP_CLEAR: begin
        dir_count = 0;
      end
      default: begin
      end
    endcase
    rsp.entry_count = lpcd_pkg::COUNT_W'(dir_count);
    return rsp;
  endfunction

  // driver: next command goes out once the current one is transferred
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || req_taken) begin
      if (pending_q.size() > 0 && !send_hold &&
          int'($urandom_range(99)) >= send_gap_pct) begin
        start_i <= 1'b1;
        req_i   <= pending_q.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check results, track config and predict accepted commands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expect_q.size() == 0) begin
          report_mismatch(-1, "result with nothing pending, count",
                          int'(rsp_o.entry_count), 0);
        end else begin
          front = expect_q.pop_front();
          if (rsp_o.hit != front.rsp.hit)
            report_mismatch(front.item, "hit", int'(rsp_o.hit), int'(front.rsp.hit));
          if (rsp_o.slot != front.rsp.slot)
            report_mismatch(front.item, "slot", int'(rsp_o.slot), int'(front.rsp.slot));
          if (rsp_o.fill_needed != front.rsp.fill_needed)
            report_mismatch(front.item, "fill_needed", int'(rsp_o.fill_needed),
                            int'(front.rsp.fill_needed));
          if (rsp_o.accepted != front.rsp.accepted)
            report_mismatch(front.item, "accepted", int'(rsp_o.accepted),
                            int'(front.rsp.accepted));
          if (rsp_o.entry_count != front.rsp.entry_count)
            report_mismatch(front.item, "entry_count", int'(rsp_o.entry_count),
                            int'(front.rsp.entry_count));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        dir_cap = cfg_data_i;
        cfg_count++;
      end
      if (start_i && !busy_o) begin
        front.rsp  = predict_directory(req_i);
        front.item = items_taken;
        expect_q.push_back(front);
        items_taken++;
        if (front.rsp.hit) hit_count++;
        if (front.rsp.fill_needed) fill_count++;
        if (!front.rsp.accepted) refused_count++;
        if (req_i.operation == lpcd_pkg::OP_CLEAR) clear_count++;
      end
      req_taken <= start_i && !busy_o;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] p1, input logic [7:0] p2);
    lpcd_pkg::lpcd_req_t r;
    r.operation    = op;
    r.first_phone  = p1;
    r.second_phone = p2;
    pending_q.push_back(r);
  endtask

  // wait for all commands and results, then let the block settle
  task automatic drain_directory();
    do @(negedge clk_i); while (pending_q.size() != 0 || start_i || expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // capacity write, only called while the block is idle
  task automatic write_capacity(input logic [lpcd_pkg::CAP_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random commands over a small key pool so that hits and evictions occur
  task automatic add_random_items(input int n, input int pool_size);
    int k;
    int sel;
    logic [lpcd_pkg::KEY_W-1:0] key;
    key_pool.delete();
    for (k = 0; k < pool_size; k++) key_pool.push_back(lpcd_pkg::KEY_W'($urandom));
    for (k = 0; k < n; k++) begin
      if ($urandom_range(7) == 0) key = lpcd_pkg::KEY_W'($urandom);
      else key = key_pool[$urandom_range(pool_size - 1)];
      sel = int'($urandom_range(99));
      if (sel < 84)      add_item(lpcd_pkg::OP_LOOKUP, key[15:8], key[7:0]);
      else if (sel < 92) add_item(lpcd_pkg::OP_PRELOAD, key[15:8], key[7:0]);
      else if (sel < 96) add_item(lpcd_pkg::OP_CLEAR, key[15:8], key[7:0]);
      else               add_item(OP_NOP, key[15:8], key[7:0]);
    end
  endtask

  // sender holds off until every pending result is back
  task automatic hold_until_empty();
    @(posedge clk_i);
    send_hold = 1'b1;
    do @(negedge clk_i); while (expect_q.size() != 0 || start_i);
    @(posedge clk_i);
    send_hold = 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    logic [lpcd_pkg::CAP_W-1:0] caps[12];
    int ph;
    int eff;
    caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd3, 5'd16, 5'd12, 5'd2, 5'd17, 5'd16};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, hits, no-op code, preload, clear at reset capacity
    send_gap_pct = 11;
    add_item(lpcd_pkg::OP_LOOKUP, 8'h00, 8'h00);
    add_item(lpcd_pkg::OP_LOOKUP, 8'hFF, 8'hFF);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h00, 8'hFF);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h00, 8'h00);
    add_item(OP_NOP, 8'hFF, 8'h00);
    add_item(lpcd_pkg::OP_PRELOAD, 8'hFF, 8'h00);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h12, 8'h34);
    add_item(lpcd_pkg::OP_LOOKUP, 8'hFF, 8'h00);
    add_item(lpcd_pkg::OP_CLEAR, 8'h00, 8'h00);
    add_item(lpcd_pkg::OP_LOOKUP, 8'hA5, 8'h5A);
    drain_directory();
    // zero capacity behaves as one: eviction and refused preload
    write_capacity(5'd0);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h5A, 8'hA5);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h01, 8'h02);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h5A, 8'hA5);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h80, 8'h01);
    drain_directory();
    // fill to capacity by preload, then refusal and back eviction
    write_capacity(5'd4);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h11, 8'h11);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h22, 8'h22);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h33, 8'h33);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h44, 8'h44);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h44, 8'h44);
    drain_directory();
    // capacity lowered below the count: count stays, back entry replaced
    write_capacity(5'd2);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h55, 8'h55);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h66, 8'h66);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h11, 8'h11);
    drain_directory();
    // capacity above the depth behaves as the depth
    write_capacity(5'd31);
    add_item(lpcd_pkg::OP_LOOKUP, 8'h77, 8'h77);
    add_item(lpcd_pkg::OP_PRELOAD, 8'h7F, 8'hFE);
    drain_directory();

    // random phases over several capacities and sender gap rates
    for (ph = 0; ph < 12; ph++) begin
      send_gap_pct = (ph < 4) ? 11 : ((ph < 8) ? 72 : 0);
      write_capacity(caps[ph]);
      eff = (caps[ph] == 0) ? 1 :
            ((int'(caps[ph]) > lpcd_pkg::ENTRIES) ? lpcd_pkg::ENTRIES : int'(caps[ph]));
      add_random_items(40, int'($urandom_range(2, 2 * eff + 4)));
      do @(negedge clk_i); while (pending_q.size() != 0);
      hold_until_empty();
      add_random_items(43, int'($urandom_range(2, 2 * eff + 4)));
      drain_directory();
    end

    while (expect_q.size() != 0) begin
      front = expect_q.pop_front();
      report_mismatch(front.item, "missing result, entry_count", 0,
                      int'(front.rsp.entry_count));
    end
    $display("covered %0d commands over %0d capacity writes: %0d hits, %0d fills,",
             items_taken, cfg_count, hit_count, fill_count);
    $display("%0d refused preloads, %0d clears, %0d mismatches",
             refused_count, clear_count, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
